FILE: rtl/tlv_container_record_parser_unit_defines.svh
// Assertion macros for the TLV container record parser.
// Used inside modules that have clk_i and rst_ni in scope.
`ifndef TLV_CONTAINER_RECORD_PARSER_UNIT_DEFINES_SVH
`define TLV_CONTAINER_RECORD_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TLVCRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLVCRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlvcrp_pkg.sv
// Types and constants of the TLV container record parser.
// Self-contained; used by tlv_container_record_parser_unit.
`timescale 1ns / 1ps
package tlvcrp_pkg;

  typedef enum logic [3:0] {
    PH_FIRST = 4'd0,
    PH_HTYPE = 4'd1,
    PH_HLEN  = 4'd2,
    PH_HVAL  = 4'd3,
    PH_HSKIP = 4'd4,
    PH_FTYPE = 4'd5,
    PH_FLEN  = 4'd6,
    PH_FVAL  = 4'd7,
    PH_DSKIP = 4'd8,
    PH_DRAIN = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0,
    EV_FILE   = 2'd1,
    EV_DONE   = 2'd2,
    EV_ERROR  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_NOTCONT = 3'd1,
    ERR_LENGTH  = 3'd2,
    ERR_TYPE    = 3'd3,
    ERR_MAGIC   = 3'd4,
    ERR_CHECK   = 3'd5,
    ERR_RANGE   = 3'd6,
    ERR_COUNT   = 3'd7
  } err_e;

  localparam logic [7:0]  FT_RSV0    = 8'h00;
  localparam logic [7:0]  FT_MAGIC   = 8'h01;
  localparam logic [7:0]  FT_VERNAME = 8'h02;
  localparam logic [7:0]  FT_LENGTH  = 8'h03;
  localparam logic [7:0]  FT_COUNT   = 8'h04;
  localparam logic [7:0]  FT_CHECK   = 8'hFE;
  localparam logic [7:0]  FT_RSV1    = 8'hFF;
  localparam logic [7:0]  FIRST_TAG  = 8'h01;
  localparam logic [7:0]  SECOND_TAG = 8'h04;
  localparam logic [31:0] MAGIC_WORD = 32'hA55AA55A;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_image;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  error_code;
    logic [15:0] version;
    logic [15:0] file_total;
    logic [15:0] file_index;
    logic [31:0] file_length;
    logic [31:0] data_offset;
    logic [7:0]  name_length;
    logic        last;
  } out_t;

endpackage

FILE: rtl/tlv_container_record_parser_unit.sv
// A byte's results are queued when it is accepted and leave when out_ready_i takes them.
// One byte per cycle while in_ready_o is high, each yielding zero, one or two items.
// Input ready drops only while the four-entry output queue cannot take two more items.
// Reset clears the parser state to "wait first byte" and empties the output queue.
// Parser state restarts from zero on the byte after each end-of-image byte.
// Depends on tlvcrp_pkg and tlv_container_record_parser_unit_defines.svh.
`timescale 1ns / 1ps
`include "tlv_container_record_parser_unit_defines.svh"
module tlv_container_record_parser_unit #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tlvcrp_pkg::in_t    in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tlvcrp_pkg::out_t   out_item_o
);

  tlvcrp_pkg::phase_e phase_q, phase_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [7:0]  first_byte_q, first_byte_d;
  logic [7:0]  field_type_q, field_type_d;
  logic [7:0]  field_rem_q, field_rem_d;
  logic [2:0]  vidx_q, vidx_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] check_q, check_d;
  logic [31:0] magic_q, magic_d;
  logic [15:0] version_q, version_d;
  logic [31:0] hdr_len_q, hdr_len_d;
  logic [15:0] files_ann_q, files_ann_d;
  logic [15:0] files_done_q, files_done_d;
  logic [31:0] rfl_q, rfl_d;
  logic [7:0]  rnl_q, rnl_d;
  logic [31:0] skip_q, skip_d;

  tlvcrp_pkg::out_t fifo_q [tlvcrp_pkg::FIFO_DEPTH];
  logic [tlvcrp_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tlvcrp_pkg::CNT_W-1:0] count_q;

  logic in_fire, out_fire;
  logic [7:0] d;
  logic eoi;
  logic [POSITION_BITS:0] consumed;
  logic [32:0] cons_ext;
  logic [31:0] part;
  logic fin, do_after, is_h;
  logic req_unknown, req_any;
  logic [7:0] req_val;
  logic [7:0] rem_dec;
  logic a_v, b_v, c_v;
  tlvcrp_pkg::event_e a_ev, b_ev;
  tlvcrp_pkg::err_e a_err, b_err;
  logic [15:0] a_idx;
  logic [31:0] a_flen, a_off;
  logic [7:0] a_nlen;
  tlvcrp_pkg::out_t res_a, res_b, res_c, res0, res1;
  logic [1:0] nres, ncand;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;
  assign d   = in_item_i.data_byte;
  assign eoi = in_item_i.end_of_image;

  assign consumed = {1'b0, pos_q} + {{POSITION_BITS{1'b0}}, 1'b1};
  assign cons_ext = 33'(consumed);

  always_comb begin
    unique case (vidx_q)
      3'd0:    part = {24'b0, d};
      3'd1:    part = {16'b0, d, 8'b0};
      3'd2:    part = {8'b0, d, 16'b0};
      3'd3:    part = {d, 24'b0};
      default: part = '0;
    endcase
  end

  always_comb begin
    is_h        = (phase_q == tlvcrp_pkg::PH_HLEN);
    req_unknown = 1'b0;
    req_any     = 1'b0;
    req_val     = 8'd0;
    unique case (field_type_q)
      tlvcrp_pkg::FT_MAGIC:   req_val = 8'd4;
      tlvcrp_pkg::FT_VERNAME: begin
        if (is_h) begin
          req_val = 8'd2;
        end else begin
          req_any = 1'b1;
        end
      end
      tlvcrp_pkg::FT_LENGTH:  req_val = 8'd4;
      tlvcrp_pkg::FT_COUNT: begin
        if (is_h) begin
          req_val = (version_q == 16'd0) ? 8'd1 : 8'd2;
        end else begin
          req_unknown = 1'b1;
        end
      end
      tlvcrp_pkg::FT_RSV0, tlvcrp_pkg::FT_RSV1: req_val = 8'd0;
      tlvcrp_pkg::FT_CHECK:   req_val = 8'd2;
      default:                req_unknown = 1'b1;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    first_byte_d = first_byte_q;
    field_type_d = field_type_q;
    field_rem_d  = field_rem_q;
    vidx_d       = vidx_q;
    sum_d        = sum_q;
    check_d      = check_q;
    magic_d      = magic_q;
    version_d    = version_q;
    hdr_len_d    = hdr_len_q;
    files_ann_d  = files_ann_q;
    files_done_d = files_done_q;
    rfl_d        = rfl_q;
    rnl_d        = rnl_q;
    skip_d       = skip_q;
    fin      = 1'b0;
    do_after = 1'b0;
    rem_dec  = field_rem_q - 8'd1;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_ev   = tlvcrp_pkg::EV_ERROR;
    b_ev   = tlvcrp_pkg::EV_ERROR;
    a_err  = tlvcrp_pkg::ERR_NONE;
    b_err  = tlvcrp_pkg::ERR_NONE;
    a_idx  = 16'd0;
    a_flen = 32'd0;
    a_off  = 32'd0;
    a_nlen = 8'd0;

    unique case (phase_q)
      tlvcrp_pkg::PH_FIRST: begin
        first_byte_d = d;
        field_type_d = d;
        sum_d        = {8'b0, d};
        phase_d      = tlvcrp_pkg::PH_HLEN;
      end
      tlvcrp_pkg::PH_HTYPE, tlvcrp_pkg::PH_FTYPE: begin
        field_type_d = d;
        sum_d        = sum_q + {8'b0, d};
        phase_d      = (phase_q == tlvcrp_pkg::PH_HTYPE) ? tlvcrp_pkg::PH_HLEN
                                                         : tlvcrp_pkg::PH_FLEN;
      end
      tlvcrp_pkg::PH_HLEN, tlvcrp_pkg::PH_FLEN: begin
        if (is_h && pos_q == POSITION_BITS'(1) && first_byte_q != tlvcrp_pkg::FIRST_TAG &&
            d != tlvcrp_pkg::SECOND_TAG) begin
          a_v   = 1'b1;
          a_err = tlvcrp_pkg::ERR_NOTCONT;
          fin   = 1'b1;
        end else if (req_unknown) begin
          a_v   = 1'b1;
          a_err = tlvcrp_pkg::ERR_TYPE;
          fin   = 1'b1;
        end else if (!req_any && d != req_val) begin
          a_v   = 1'b1;
          a_err = tlvcrp_pkg::ERR_LENGTH;
          fin   = 1'b1;
        end else begin
          sum_d       = sum_q + {8'b0, d};
          vidx_d      = 3'd0;
          field_rem_d = d;
          unique case (field_type_q)
            tlvcrp_pkg::FT_MAGIC:   magic_d = '0;
            tlvcrp_pkg::FT_VERNAME: begin
              if (is_h) begin
                version_d = '0;
              end else begin
                rnl_d = d;
              end
            end
            tlvcrp_pkg::FT_LENGTH: begin
              if (is_h) begin
                hdr_len_d = '0;
              end else begin
                rfl_d = '0;
              end
            end
            tlvcrp_pkg::FT_COUNT:   files_ann_d = '0;
            tlvcrp_pkg::FT_CHECK:   check_d = '0;
            default: ;
          endcase
          if (is_h) begin
            phase_d = (d == 8'd0) ? tlvcrp_pkg::PH_HTYPE : tlvcrp_pkg::PH_HVAL;
          end else begin
            phase_d = (d == 8'd0) ? tlvcrp_pkg::PH_FTYPE : tlvcrp_pkg::PH_FVAL;
          end
        end
      end
      tlvcrp_pkg::PH_HVAL, tlvcrp_pkg::PH_FVAL: begin
        if (field_type_q != tlvcrp_pkg::FT_CHECK) begin
          sum_d = sum_q + {8'b0, d};
        end
        unique case (field_type_q)
          tlvcrp_pkg::FT_MAGIC: magic_d = magic_q | part;
          tlvcrp_pkg::FT_VERNAME: begin
            if (phase_q == tlvcrp_pkg::PH_HVAL) begin
              version_d = version_q | part[15:0];
            end
          end
          tlvcrp_pkg::FT_LENGTH: begin
            if (phase_q == tlvcrp_pkg::PH_HVAL) begin
              hdr_len_d = hdr_len_q | part;
            end else begin
              rfl_d = rfl_q | part;
            end
          end
          tlvcrp_pkg::FT_COUNT: files_ann_d = files_ann_q | part[15:0];
          tlvcrp_pkg::FT_CHECK: check_d = check_q | part[15:0];
          default: ;
        endcase
        vidx_d      = (vidx_q == 3'd4) ? 3'd4 : vidx_q + 3'd1;
        field_rem_d = rem_dec;
        if (rem_dec == 8'd0) begin
          if (field_type_q != tlvcrp_pkg::FT_CHECK) begin
            phase_d = (phase_q == tlvcrp_pkg::PH_HVAL) ? tlvcrp_pkg::PH_HTYPE
                                                       : tlvcrp_pkg::PH_FTYPE;
          end else if (magic_d != tlvcrp_pkg::MAGIC_WORD) begin
            a_v   = 1'b1;
            a_err = tlvcrp_pkg::ERR_MAGIC;
            fin   = 1'b1;
          end else if (sum_d != check_d) begin
            a_v   = 1'b1;
            a_err = tlvcrp_pkg::ERR_CHECK;
            fin   = 1'b1;
          end else if (phase_q == tlvcrp_pkg::PH_HVAL) begin
            a_v     = 1'b1;
            a_ev    = tlvcrp_pkg::EV_HEADER;
            skip_d  = ({1'b0, hdr_len_d} > cons_ext) ? 32'({1'b0, hdr_len_d} - cons_ext)
                                                     : 32'd0;
            phase_d = tlvcrp_pkg::PH_HSKIP;
            do_after = (skip_d == 32'd0);
          end else begin
            a_v          = 1'b1;
            a_ev         = tlvcrp_pkg::EV_FILE;
            a_idx        = files_done_q;
            a_flen       = rfl_d;
            a_off        = 32'(consumed[POSITION_BITS-1:0]);
            a_nlen       = rnl_d;
            files_done_d = files_done_q + 16'd1;
            skip_d       = rfl_d;
            phase_d      = tlvcrp_pkg::PH_DSKIP;
            do_after     = (rfl_d == 32'd0);
          end
        end
      end
      tlvcrp_pkg::PH_HSKIP, tlvcrp_pkg::PH_DSKIP: begin
        skip_d   = skip_q - 32'd1;
        do_after = (skip_d == 32'd0);
      end
      default: ;
    endcase

    if (do_after) begin
      if (files_done_d == files_ann_d) begin
        b_v  = 1'b1;
        b_ev = tlvcrp_pkg::EV_DONE;
        fin  = 1'b1;
      end else if (eoi) begin
        b_v   = 1'b1;
        b_err = tlvcrp_pkg::ERR_COUNT;
        fin   = 1'b1;
      end else begin
        sum_d   = '0;
        magic_d = '0;
        check_d = '0;
        rfl_d   = '0;
        rnl_d   = '0;
        phase_d = tlvcrp_pkg::PH_FTYPE;
      end
    end

    if (eoi && !fin && phase_d != tlvcrp_pkg::PH_DRAIN) begin
      c_v = 1'b1;
      fin = 1'b1;
    end

    res_a = '{event_res: a_ev, error_code: a_err, version: version_d,
              file_total: files_ann_d, file_index: a_idx, file_length: a_flen,
              data_offset: a_off, name_length: a_nlen, last: 1'b0};
    res_b = '{event_res: b_ev, error_code: b_err, version: version_d,
              file_total: files_ann_d, file_index: 16'd0, file_length: 32'd0,
              data_offset: 32'd0, name_length: 8'd0, last: 1'b0};
    res_c = '{event_res: tlvcrp_pkg::EV_ERROR, error_code: tlvcrp_pkg::ERR_RANGE,
              version: version_d, file_total: files_ann_d, file_index: 16'd0,
              file_length: 32'd0, data_offset: 32'd0, name_length: 8'd0, last: 1'b0};

    pos_d = consumed[POSITION_BITS-1:0];
    if (eoi) begin
      phase_d      = tlvcrp_pkg::PH_FIRST;
      pos_d        = '0;
      first_byte_d = '0;
      field_type_d = '0;
      field_rem_d  = '0;
      vidx_d       = '0;
      sum_d        = '0;
      check_d      = '0;
      magic_d      = '0;
      version_d    = '0;
      hdr_len_d    = '0;
      files_ann_d  = '0;
      files_done_d = '0;
      rfl_d        = '0;
      rnl_d        = '0;
      skip_d       = '0;
    end else if (fin) begin
      phase_d = tlvcrp_pkg::PH_DRAIN;
    end
  end

  always_comb begin
    ncand = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
    nres  = (ncand > 2'd2) ? 2'd2 : ncand;
    res0  = a_v ? res_a : (b_v ? res_b : res_c);
    res1  = (a_v && b_v) ? res_b : res_c;
    res0.last = (nres == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tlvcrp_pkg::PH_FIRST;
      pos_q        <= '0;
      first_byte_q <= '0;
      field_type_q <= '0;
      field_rem_q  <= '0;
      vidx_q       <= '0;
      sum_q        <= '0;
      check_q      <= '0;
      magic_q      <= '0;
      version_q    <= '0;
      hdr_len_q    <= '0;
      files_ann_q  <= '0;
      files_done_q <= '0;
      rfl_q        <= '0;
      rnl_q        <= '0;
      skip_q       <= '0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      first_byte_q <= first_byte_d;
      field_type_q <= field_type_d;
      field_rem_q  <= field_rem_d;
      vidx_q       <= vidx_d;
      sum_q        <= sum_d;
      check_q      <= check_d;
      magic_q      <= magic_d;
      version_q    <= version_d;
      hdr_len_q    <= hdr_len_d;
      files_ann_q  <= files_ann_d;
      files_done_q <= files_done_d;
      rfl_q        <= rfl_d;
      rnl_q        <= rnl_d;
      skip_q       <= skip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + tlvcrp_pkg::PTR_W'(nres);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + tlvcrp_pkg::PTR_W'(1);
      end
      count_q <= count_q + (in_fire ? tlvcrp_pkg::CNT_W'(nres) : '0)
                 - tlvcrp_pkg::CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && nres != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_fire && nres == 2'd2) begin
      fifo_q[wr_ptr_q + tlvcrp_pkg::PTR_W'(1)] <= res1;
    end
  end

  assign in_ready_o  = (count_q <= tlvcrp_pkg::CNT_W'(tlvcrp_pkg::FIFO_DEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = fifo_q[rd_ptr_q];

  `TLVCRP_ASSERT_IMP(a_count_range, 1'b1,
    count_q <= tlvcrp_pkg::CNT_W'(tlvcrp_pkg::FIFO_DEPTH), "output queue overflow")
  `TLVCRP_ASSERT_NEXT(a_count_track, in_fire && !out_fire,
    count_q == $past(count_q + {1'b0, nres}), "output queue count lost items")
  `TLVCRP_ASSERT_NEXT(a_eoi_restart, in_fire && eoi,
    phase_q == tlvcrp_pkg::PH_FIRST && pos_q == '0, "no restart after end of image")
  `TLVCRP_ASSERT_IMP(a_err_code, out_valid_o && out_item_o.event_res != tlvcrp_pkg::EV_ERROR,
    out_item_o.error_code == tlvcrp_pkg::ERR_NONE, "error code on non-error item")
  `TLVCRP_ASSERT_IMP(a_file_fields, out_valid_o && out_item_o.event_res != tlvcrp_pkg::EV_FILE,
    out_item_o.file_index == '0 && out_item_o.data_offset == '0, "file fields on other item")

endmodule

FILE: tb/sv/tlv_record_parse_checker.sv
// Checker for the TLV container record parser: watches both item channels,
// predicts the result items of each accepted byte and compares them in order.
// Depends on tlvcrp_pkg for the item types, event and error codes.
`timescale 1ns / 1ps
module tlv_record_parse_checker #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  tlvcrp_pkg::in_t  in_item_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  tlvcrp_pkg::out_t out_item_i,
  output int               pending_o,
  output int               fail_count_o,
  output int               results_o,
  output int               faults_o
);
  import tlvcrp_pkg::*;

  localparam int LEN_BAD = -1;
  localparam int LEN_ANY = -2;
  localparam logic [31:0] POS_MASK = 32'((64'd1 << POSITION_BITS) - 64'd1);

  phase_e      ph;
  logic [31:0] byte_pos;
  logic [7:0]  first_byte;
  logic [7:0]  fld_type;
  logic [7:0]  fld_left;
  logic [31:0] shift_amt;
  logic [15:0] rec_sum;
  logic [15:0] stored_ck;
  logic [31:0] magic_acc;
  logic [15:0] ver_q;
  logic [31:0] hdr_len;
  logic [15:0] files_ann;
  logic [15:0] files_done;
  logic [31:0] rec_flen;
  logic [7:0]  rec_nlen;
  logic [31:0] skip_left;

  out_t res_buf [2];
  int   res_n;
  bit   fin_f;

  out_t expected_events [$];
  int   fail_cnt;
  int   results_seen;
  int   fault_events;

  assign fail_count_o = fail_cnt;
  assign results_o    = results_seen;
  assign faults_o     = fault_events;

  task automatic clear_image();
    ph         = PH_FIRST;
    byte_pos   = '0;
    first_byte = '0;
    fld_type   = '0;
    fld_left   = '0;
    shift_amt  = '0;
    rec_sum    = '0;
    stored_ck  = '0;
    magic_acc  = '0;
    ver_q      = '0;
    hdr_len    = '0;
    files_ann  = '0;
    files_done = '0;
    rec_flen   = '0;
    rec_nlen   = '0;
    skip_left  = '0;
  endtask

  task automatic push_res(input event_e ev, input err_e er, input logic [15:0] idx,
                          input logic [31:0] flen, input logic [31:0] off,
                          input logic [7:0] nlen);
    out_t r;
    r = '0;
    r.event_res   = ev;
    r.error_code  = er;
    r.version     = ver_q;
    r.file_total  = files_ann;
    r.file_index  = idx;
    r.file_length = flen;
    r.data_offset = off;
    r.name_length = nlen;
    if (res_n < 2) begin
      res_buf[res_n] = r;
      res_n++;
    end
  endtask

  task automatic fault(input err_e er);
    push_res(EV_ERROR, er, '0, '0, '0, '0);
    fin_f = 1'b1;
  endtask

  // Next record boundary reached: finish, flag a short image, or open a file record.
  task automatic record_start(input logic eoi);
    if (files_done == files_ann) begin
      push_res(EV_DONE, ERR_NONE, '0, '0, '0, '0);
      fin_f = 1'b1;
    end else if (eoi) begin
      fault(ERR_COUNT);
    end else begin
      rec_sum   = '0;
      magic_acc = '0;
      stored_ck = '0;
      rec_flen  = '0;
      rec_nlen  = '0;
      ph        = PH_FTYPE;
    end
  endtask

  function automatic int need_len(input bit in_hdr, input logic [7:0] t);
    case (t)
      FT_MAGIC, FT_LENGTH: return 4;
      FT_VERNAME:          return in_hdr ? 2 : LEN_ANY;
      FT_COUNT:            return in_hdr ? ((ver_q == '0) ? 1 : 2) : LEN_BAD;
      FT_RSV0, FT_RSV1:    return 0;
      FT_CHECK:            return 2;
      default:             return LEN_BAD;
    endcase
  endfunction

  task automatic parse_byte(input in_t it);
    logic [7:0]  d;
    logic        eoi;
    logic [31:0] pos;
    logic [32:0] consumed;
    logic [31:0] part;
    bit          hdr;
    int          req;
    d        = it.data_byte;
    eoi      = it.end_of_image;
    pos      = byte_pos;
    consumed = {1'b0, pos} + 33'd1;
    part     = (shift_amt < 32'd32) ? ({24'd0, d} << shift_amt[4:0]) : 32'd0;
    res_n    = 0;
    fin_f    = 1'b0;
    case (ph)
      PH_FIRST: begin
        first_byte = d;
        fld_type   = d;
        rec_sum    = {8'd0, d};
        ph         = PH_HLEN;
      end
      PH_HTYPE, PH_FTYPE: begin
        fld_type = d;
        rec_sum  = rec_sum + {8'd0, d};
        ph       = (ph == PH_HTYPE) ? PH_HLEN : PH_FLEN;
      end
      PH_HLEN, PH_FLEN: begin
        hdr = (ph == PH_HLEN);
        req = need_len(hdr, fld_type);
        if (hdr && pos == 32'd1 && first_byte != FIRST_TAG && d != SECOND_TAG) begin
          fault(ERR_NOTCONT);
        end else if (req == LEN_BAD) begin
          fault(ERR_TYPE);
        end else if (req >= 0 && int'(d) != req) begin
          fault(ERR_LENGTH);
        end else begin
          rec_sum   = rec_sum + {8'd0, d};
          shift_amt = '0;
          fld_left  = d;
          case (fld_type)
            FT_MAGIC:   magic_acc = '0;
            FT_VERNAME: if (hdr) ver_q = '0; else rec_nlen = d;
            FT_LENGTH:  if (hdr) hdr_len = '0; else rec_flen = '0;
            FT_COUNT:   files_ann = '0;
            FT_CHECK:   stored_ck = '0;
            default:    ;
          endcase
          if (hdr) ph = (d == 8'd0) ? PH_HTYPE : PH_HVAL;
          else ph = (d == 8'd0) ? PH_FTYPE : PH_FVAL;
        end
      end
      PH_HVAL, PH_FVAL: begin
        hdr = (ph == PH_HVAL);
        if (fld_type != FT_CHECK) rec_sum = rec_sum + {8'd0, d};
        case (fld_type)
          FT_MAGIC:   magic_acc = magic_acc | part;
          FT_VERNAME: if (hdr) ver_q = ver_q | part[15:0];
          FT_LENGTH:  if (hdr) hdr_len = hdr_len | part; else rec_flen = rec_flen | part;
          FT_COUNT:   files_ann = files_ann | part[15:0];
          FT_CHECK:   stored_ck = stored_ck | part[15:0];
          default:    ;
        endcase
        shift_amt = shift_amt + 32'd8;
        fld_left  = fld_left - 8'd1;
        if (fld_left == 8'd0) begin
          if (fld_type != FT_CHECK) begin
            ph = hdr ? PH_HTYPE : PH_FTYPE;
          end else if (magic_acc != MAGIC_WORD) begin
            fault(ERR_MAGIC);
          end else if (rec_sum != stored_ck) begin
            fault(ERR_CHECK);
          end else begin
            if (hdr) begin
              push_res(EV_HEADER, ERR_NONE, '0, '0, '0, '0);
              skip_left = ({1'b0, hdr_len} > consumed) ?
                          32'({1'b0, hdr_len} - consumed) : 32'd0;
              ph = PH_HSKIP;
            end else begin
              push_res(EV_FILE, ERR_NONE, files_done, rec_flen,
                       consumed[31:0] & POS_MASK, rec_nlen);
              files_done = files_done + 16'd1;
              skip_left  = rec_flen;
              ph         = PH_DSKIP;
            end
            if (skip_left == 32'd0) record_start(eoi);
          end
        end
      end
      PH_HSKIP, PH_DSKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) record_start(eoi);
      end
      default: ;
    endcase
    if (eoi && !fin_f && ph != PH_DRAIN) fault(ERR_RANGE);
    byte_pos = consumed[31:0] & POS_MASK;
    if (eoi) clear_image();
    else if (fin_f) ph = PH_DRAIN;
    for (int k = 0; k < res_n; k++) begin
      res_buf[k].last = (k == res_n - 1);
      expected_events.push_back(res_buf[k]);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fail_cnt++;
    $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
             $time, results_seen, what, got, want);
  endtask

  task automatic check_event(input out_t got);
    out_t want;
    results_seen++;
    if (expected_events.size() == 0) begin
      flag_mismatch("unexpected item, event_res", 32'(got.event_res), 32'd0);
    end else begin
      want = expected_events.pop_front();
      if (want.event_res == EV_ERROR) fault_events++;
      if (got.event_res !== want.event_res)
        flag_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
      if (got.error_code !== want.error_code)
        flag_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
      if (got.version !== want.version)
        flag_mismatch("version", 32'(got.version), 32'(want.version));
      if (got.file_total !== want.file_total)
        flag_mismatch("file_total", 32'(got.file_total), 32'(want.file_total));
      if (got.file_index !== want.file_index)
        flag_mismatch("file_index", 32'(got.file_index), 32'(want.file_index));
      if (got.file_length !== want.file_length)
        flag_mismatch("file_length", got.file_length, want.file_length);
      if (got.data_offset !== want.data_offset)
        flag_mismatch("data_offset", got.data_offset, want.data_offset);
      if (got.name_length !== want.name_length)
        flag_mismatch("name_length", 32'(got.name_length), 32'(want.name_length));
      if (got.last !== want.last)
        flag_mismatch("last", 32'(got.last), 32'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_image();
      expected_events.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_byte(in_item_i);
      if (out_valid_i && out_ready_i) check_event(out_item_i);
      pending_o <= expected_events.size();
    end
  end

endmodule

FILE: tb/sv/tlv_container_record_parser_unit_tb.sv
// Top of the TLV container record parser testbench: builds container images
// (directed, well-formed, damaged, noise), drives them byte by byte and stalls the output.
// Depends on tlvcrp_pkg, tlv_container_record_parser_unit and tlv_record_parse_checker.
`timescale 1ns / 1ps
module tlv_container_record_parser_unit_tb;
  import tlvcrp_pkg::*;

  localparam int unsigned POSITION_BITS = 32;
  localparam int          RANDOM_BYTES  = 1450;
  localparam int          LIMIT_CYCLES  = 1000000;
  localparam int          HOLD_CYCLES   = 150;
  localparam int          DRAIN_CYCLES  = 20;
  localparam int          DIRECTED_N    = 20;
  // {end_of_image, data_byte}
  localparam logic [8:0] DIRECTED [DIRECTED_N] = '{
    9'h000, 9'h1FF,
    9'h007, 9'h104,
    9'h001, 9'h105,
    9'h101,
    9'h001, 9'h004, 9'h05A, 9'h0A5, 9'h05A, 9'h0A5,
    9'h004, 9'h001, 9'h001, 9'h0FE, 9'h002, 9'h009, 9'h103
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_item;
  logic out_valid;
  logic out_ready;
  out_t out_item;

  int pending;
  int fail_count;
  int results;
  int faults;
  int cycles;
  int sent_cnt;
  bit hold_busy;
  int images;

  in_t        stim_q [$];
  logic [7:0] img_b [$];
  int         rec_starts [$];

  tlv_container_record_parser_unit #(
    .POSITION_BITS(POSITION_BITS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  tlv_record_parse_checker #(
    .POSITION_BITS(POSITION_BITS)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .pending_o   (pending),
    .fail_count_o(fail_count),
    .results_o   (results),
    .faults_o    (faults)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_field(input logic [7:0] ftype, input int nbytes,
                           input logic [31:0] val);
    img_b.push_back(ftype);
    img_b.push_back(8'(nbytes));
    for (int k = 0; k < nbytes; k++)
      img_b.push_back((k < 4) ? val[8*k +: 8] : 8'($urandom));
  endtask

  task automatic seal_record(input int start);
    logic [15:0] sum;
    sum = '0;
    img_b.push_back(FT_CHECK);
    img_b.push_back(8'd2);
    for (int k = start; k < img_b.size(); k++) sum = sum + {8'd0, img_b[k]};
    img_b.push_back(sum[7:0]);
    img_b.push_back(sum[15:8]);
  endtask

  // Output side: random stalls, plus two long hold-offs while input is offered without gaps.
  initial begin
    int unsigned stall;
    int unsigned run;
    int          press_idx;
    press_idx = 0;
    out_ready <= 1'b0;
    hold_busy <= 1'b0;
    @(posedge clk);
    forever begin
      if (press_idx < 2 && sent_cnt >= ((press_idx == 0) ? 300 : 1000)) begin
        out_ready <= 1'b0;
        hold_busy <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_busy <= 1'b0;
        press_idx++;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    in_t         it;
    int          n_files;
    int          n_emit;
    int          len_at;
    int          start;
    int          hdr_size;
    int unsigned hdr_len;
    int unsigned flen;
    int unsigned nlen;
    int unsigned kind;
    int unsigned gap;
    int          ord [4];
    int          j;
    int          t;
    bit          ver_nz;
    bit          has_rsv;
    bit          has_name;
    bit          has_len;
    logic [15:0] vers;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    sent_cnt <= 0;
    images   = 5;

    for (int k = 0; k < DIRECTED_N; k++) begin
      it.data_byte    = DIRECTED[k][7:0];
      it.end_of_image = DIRECTED[k][8];
      stim_q.push_back(it);
    end

    while (stim_q.size() < DIRECTED_N + RANDOM_BYTES) begin
      img_b.delete();
      rec_starts.delete();
      n_files = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 4));
      ver_nz  = 1'b0;
      has_rsv = 1'($urandom_range(0, 1));
      len_at  = 0;

      // header record: magic first, the rest in random order
      put_field(FT_MAGIC, 4, MAGIC_WORD);
      for (int k = 0; k < 4; k++) ord[k] = k;
      for (int k = 3; k > 0; k--) begin
        j = int'($urandom_range(0, k));
        t = ord[k]; ord[k] = ord[j]; ord[j] = t;
      end
      for (int k = 0; k < 4; k++) begin
        case (ord[k])
          0: begin
            t = int'($urandom_range(0, 7));
            vers = (t < 2) ? 16'h0000 : ((t == 2) ? 16'hFFFF : 16'($urandom));
            put_field(FT_VERNAME, 2, {16'd0, vers});
            ver_nz = (vers != 16'h0000);
          end
          1: put_field(FT_COUNT, ver_nz ? 2 : 1, 32'(n_files));
          2: begin
            put_field(FT_LENGTH, 4, 32'd0);
            len_at = img_b.size() - 4;
          end
          default: if (has_rsv) put_field($urandom_range(0, 1) ? FT_RSV1 : FT_RSV0, 0, 32'd0);
        endcase
      end
      hdr_size = img_b.size() + 4;
      hdr_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, hdr_size) :
                int'(hdr_size) + $urandom_range(0, 6);
      for (int k = 0; k < 4; k++) img_b[len_at + k] = hdr_len[8*k +: 8];
      seal_record(0);
      while (img_b.size() < int'(hdr_len)) img_b.push_back(8'($urandom));

      for (int f = 0; f < n_files; f++) begin
        rec_starts.push_back(img_b.size());
        start    = img_b.size();
        has_rsv  = ($urandom_range(0, 3) == 0);
        has_name = ($urandom_range(0, 3) != 0);
        has_len  = ($urandom_range(0, 4) != 0);
        nlen = ($urandom_range(0, 39) == 0) ? $urandom_range(40, 255) : $urandom_range(0, 6);
        flen = !has_len ? 0 :
               (($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8));
        for (int k = 0; k < 4; k++) ord[k] = k;
        for (int k = 3; k > 0; k--) begin
          j = int'($urandom_range(0, k));
          t = ord[k]; ord[k] = ord[j]; ord[j] = t;
        end
        for (int k = 0; k < 4; k++) begin
          case (ord[k])
            0: put_field(FT_MAGIC, 4, MAGIC_WORD);
            1: if (has_name) put_field(FT_VERNAME, int'(nlen), $urandom);
            2: if (has_len) put_field(FT_LENGTH, 4, flen);
            default: if (has_rsv) put_field($urandom_range(0, 1) ? FT_RSV1 : FT_RSV0, 0, 32'd0);
          endcase
        end
        seal_record(start);
        repeat (flen) img_b.push_back(8'($urandom));
      end
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) img_b.push_back(8'($urandom));

      // damage a share of the images
      kind   = $urandom_range(0, 9);
      n_emit = img_b.size();
      if (kind == 6) begin
        j = int'($urandom_range(0, img_b.size() - 1));
        img_b[j] = img_b[j] ^ 8'($urandom_range(1, 255));
      end else if (kind == 7 || (kind == 8 && rec_starts.size() == 0)) begin
        n_emit = int'($urandom_range(1, img_b.size()));
      end else if (kind == 8) begin
        n_emit = rec_starts[$urandom_range(0, rec_starts.size() - 1)];
      end else if (kind == 9) begin
        img_b.delete();
        repeat ($urandom_range(1, 16)) img_b.push_back(8'($urandom));
        if ($urandom_range(0, 1)) img_b[0] = FIRST_TAG;
        n_emit = img_b.size();
      end
      for (int k = 0; k < n_emit; k++) begin
        it.data_byte    = img_b[k];
        it.end_of_image = (k == n_emit - 1);
        stim_q.push_back(it);
      end
      images++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < stim_q.size(); i++) begin
      gap = pick_gap();
      if (gap != 0 && !hold_busy && ((i / 150) % 3 != 0)) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= stim_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent_cnt <= sent_cnt + 1;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes over %0d container images under random idling.",
             stim_q.size(), images);
    $display("Checked %0d result items, %0d of them error events, with two %0d-cycle stalls.",
             results, faults, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
